// ===== rtl/rsrp_pkg.sv =====
// Shared types, character codes, result kinds and byte-parsing functions of the reply parser.
package rsrp_pkg;

  localparam int VALUE_BITS = 16;
  localparam int OUT_MAX = 65535;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_EQ = 8'h3d;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UD = 8'h44;
  localparam logic [7:0] CH_UT = 8'h54;
  localparam logic [7:0] CH_UM = 8'h4d;
  localparam logic [7:0] CH_US = 8'h53;
  localparam logic [7:0] CH_UL = 8'h4c;
  localparam logic [7:0] CH_UI = 8'h49;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF_F = 8'h66;
  localparam logic [7:0] CH_LI = 8'h69;
  localparam logic [7:0] CH_LK = 8'h6b;
  localparam logic [7:0] CH_LL = 8'h6c;
  localparam logic [7:0] CH_LO = 8'h6f;

  localparam logic [3:0] KIND_DISTANCE = 4'd0;
  localparam logic [3:0] KIND_OK = 4'd1;
  localparam logic [3:0] KIND_FAIL = 4'd2;
  localparam logic [3:0] KIND_OFFSET = 4'd3;
  localparam logic [3:0] KIND_INTERVAL = 4'd4;
  localparam logic [3:0] KIND_MAX_RANGE = 4'd5;
  localparam logic [3:0] KIND_FILTER = 4'd6;
  localparam logic [3:0] KIND_MODE = 4'd7;
  localparam logic [3:0] KIND_ADDRESS = 4'd8;
  localparam logic [3:0] KIND_UNKNOWN = 4'd9;
  localparam logic [3:0] KIND_MALFORMED = 4'd10;

  localparam logic [VALUE_BITS-1:0] ACC_MAX = '1;

  typedef struct packed {
    logic [2:0] pos;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    logic [VALUE_BITS-1:0] acc;
    logic digit_seen;
    logic equal_seen;
    logic hash_seen;
    logic lead_done;
  } line_t;

  typedef struct packed {
    logic emit;
    logic [3:0] kind;
    logic [15:0] value;
    logic upd_distance;
    logic upd_offset;
    logic upd_interval;
    logic upd_max_range;
    logic upd_filter;
    logic upd_mode;
    logic upd_address;
    logic acc_nonzero;
  } cls_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [VALUE_BITS-1:0] acc_add(logic [VALUE_BITS-1:0] acc,
                                                    logic [7:0] c);
    logic [VALUE_BITS+3:0] v;
    v = {4'b0, acc} * (VALUE_BITS+4)'(10) + (VALUE_BITS+4)'(c[3:0]);
    return (v > (VALUE_BITS+4)'(ACC_MAX)) ? ACC_MAX : v[VALUE_BITS-1:0];
  endfunction

  function automatic line_t take_byte(line_t s, logic [7:0] c);
    line_t n;
    n = s;
    case (s.pos)
      3'd0: n.c0 = c;
      3'd1: n.c1 = c;
      3'd2: n.c2 = c;
      3'd3: n.c3 = c;
      default: ;
    endcase
    if (s.pos == 3'd0 && is_digit(c)) begin
      n.acc = VALUE_BITS'(c[3:0]);
      n.digit_seen = 1'b1;
    end else if (s.pos != 3'd0 && is_digit(s.c0)) begin
      if (!s.lead_done) begin
        if (is_digit(c)) begin
          n.acc = acc_add(s.acc, c);
        end else begin
          n.lead_done = 1'b1;
        end
      end
    end else if (!s.hash_seen) begin
      if (c == CH_HASH) begin
        n.hash_seen = 1'b1;
      end else if (s.equal_seen && is_digit(c)) begin
        n.acc = acc_add(s.acc, c);
        n.digit_seen = 1'b1;
      end else if (c == CH_EQ) begin
        n.equal_seen = 1'b1;
      end
    end
    if (s.pos != 3'd7) begin
      n.pos = s.pos + 3'd1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/rsrp_line.sv =====
// Line state registers: absorbs received bytes and detects the CR LF line end.
module rsrp_line
  import rsrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] rx_byte,
  output line_t      line,
  output logic       line_end
);

  line_t line_next;
  logic prev_cr;
  logic prev_cr_next;
  line_t after_cr;

  assign line_end = prev_cr && (rx_byte == CH_LF);

  always_comb begin
    after_cr = prev_cr ? take_byte(line, CH_CR) : line;
    line_next = line;
    prev_cr_next = prev_cr;
    if (line_end) begin
      line_next = '0;
      prev_cr_next = 1'b0;
    end else if (rx_byte == CH_CR) begin
      line_next = after_cr;
      prev_cr_next = 1'b1;
    end else begin
      line_next = take_byte(after_cr, rx_byte);
      prev_cr_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line <= '0;
      prev_cr <= 1'b0;
    end else if (advance) begin
      line <= line_next;
      prev_cr <= prev_cr_next;
    end
  end

endmodule

// ===== rtl/rsrp_classify.sv =====
// Classifies a finished line into a result kind, a value and reading updates.
module rsrp_classify
  import rsrp_pkg::*;
(
  input  line_t line,
  output cls_t  cls
);

  logic [15:0] v16;
  logic known_key;

  always_comb begin
    v16 = (line.acc > VALUE_BITS'(OUT_MAX)) ? 16'hffff : 16'(line.acc);
    known_key = (line.c0 == CH_UD) || (line.c0 == CH_UT) || (line.c0 == CH_UM) ||
                (line.c0 == CH_US) || (line.c0 == CH_UL) || (line.c0 == CH_UI);
    cls = '0;
    cls.acc_nonzero = (line.acc != '0);
    if (line.pos == 3'd0) begin
      cls.emit = 1'b0;
    end else if (is_digit(line.c0)) begin
      cls.emit = 1'b1;
      cls.kind = KIND_DISTANCE;
      cls.value = v16;
      cls.upd_distance = 1'b1;
    end else if (line.c0 == CH_LO && line.c1 == CH_LK) begin
      cls.emit = 1'b1;
      cls.kind = KIND_OK;
    end else if (line.c0 == CH_LF_F && line.c1 == CH_LA &&
                 line.c2 == CH_LI && line.c3 == CH_LL) begin
      cls.emit = 1'b1;
      cls.kind = KIND_FAIL;
    end else if (!line.equal_seen) begin
      cls.emit = 1'b0;
    end else if (!known_key) begin
      cls.emit = 1'b1;
      cls.kind = KIND_UNKNOWN;
    end else if (!line.digit_seen) begin
      cls.emit = 1'b1;
      cls.kind = KIND_MALFORMED;
    end else begin
      cls.emit = 1'b1;
      cls.value = v16;
      case (line.c0)
        CH_UD: begin
          cls.kind = KIND_OFFSET;
          cls.upd_offset = 1'b1;
        end
        CH_UT: begin
          cls.kind = KIND_INTERVAL;
          cls.upd_interval = 1'b1;
        end
        CH_UM: begin
          if (line.c1 == CH_LA) begin
            cls.kind = KIND_MAX_RANGE;
            cls.upd_max_range = 1'b1;
          end else begin
            cls.kind = KIND_FILTER;
            cls.upd_filter = 1'b1;
          end
        end
        CH_US: begin
          cls.kind = KIND_MODE;
          cls.upd_mode = 1'b1;
        end
        CH_UL: begin
          cls.kind = KIND_DISTANCE;
          cls.upd_distance = 1'b1;
        end
        default: begin
          cls.kind = KIND_ADDRESS;
          cls.upd_address = 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/range_sensor_reply_parser.sv =====
// Top level of the range sensor reply parser: input register, line logic, result register.
// The LF that ends a line passes the input register before its result enters the result
// register. Throughput: one byte per cycle unless an emitting line end meets a waiting
// result; the input register takes a byte while a result waits unless it holds such an end.
// The path from input register to result register is one pass of the line update logic.
// Reset clears the line state, the stored readings and both valid flags.
module range_sensor_reply_parser
  import rsrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [3:0] line_kind, [19:4] line_value, [23:20] zero
);

  logic in_valid;
  logic [7:0] in_byte;
  line_t line;
  logic line_end;
  cls_t cls;
  logic emit;
  logic advance;
  logic [3:0] out_kind;
  logic [15:0] out_value;

  logic [15:0] last_distance;
  logic [15:0] last_offset;
  logic [15:0] last_interval;
  logic [15:0] last_max_range;
  logic filter_enabled;
  logic receive_mode;
  logic [7:0] device_address;

  rsrp_line u_line (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .rx_byte  (in_byte),
    .line     (line),
    .line_end (line_end)
  );

  rsrp_classify u_classify (
    .line (line),
    .cls  (cls)
  );

  assign emit = line_end && cls.emit;
  assign advance = in_valid && (!emit || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tdata = {4'b0, out_value, out_kind};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_kind <= cls.kind;
      out_value <= cls.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_distance <= '0;
      last_offset <= '0;
      last_interval <= '0;
      last_max_range <= '0;
      filter_enabled <= 1'b0;
      receive_mode <= 1'b0;
      device_address <= '0;
    end else if (advance && line_end) begin
      if (cls.upd_distance) last_distance <= cls.value;
      if (cls.upd_offset) last_offset <= cls.value;
      if (cls.upd_interval) last_interval <= cls.value;
      if (cls.upd_max_range) last_max_range <= cls.value;
      if (cls.upd_filter) filter_enabled <= cls.acc_nonzero;
      if (cls.upd_mode) receive_mode <= cls.acc_nonzero;
      if (cls.upd_address) device_address <= line.acc[7:0];
    end
  end

endmodule

// ===== rtl/rsrp_checker.sv =====
// Port-level checker for the reply parser and its bind to the top level.
module rsrp_checker
  import rsrp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result changed or dropped.");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= KIND_MALFORMED && m_tdata[23:20] == 4'b0)
    else $error("Result kind out of range or padding set.");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:0] == KIND_OK || m_tdata[3:0] == KIND_FAIL ||
                 m_tdata[3:0] == KIND_UNKNOWN || m_tdata[3:0] == KIND_MALFORMED)
    |-> m_tdata[19:4] == 16'h0)
    else $error("Status or error result carries a value.");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("Result valid right after reset.");

endmodule

bind range_sensor_reply_parser rsrp_checker u_rsrp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
